// ----- hw/rtl/buzzer_alert_pattern_sequencer_core_macros.svh -----
// Assertion macros used by the top level of the buzzer alert pattern sequencer RTL.
`ifndef BUZZER_ALERT_PATTERN_SEQUENCER_CORE_MACROS_SVH
`define BUZZER_ALERT_PATTERN_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BAPSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BAPSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bapsc_pkg.sv -----
// Types and constants shared by the buzzer alert pattern sequencer modules.
package bapsc_pkg;

  localparam logic [1:0] PH_ARMING    = 2'd0;
  localparam logic [1:0] PH_COUNTDOWN = 2'd1;
  localparam logic [1:0] PH_OTHER     = 2'd2;
  localparam logic [1:0] PH_RESERVED  = 2'd3;

  localparam logic [1:0] MODE_PASSIVE     = 2'd0;
  localparam logic [1:0] MODE_ACTIVE_HIGH = 2'd1;
  localparam logic [1:0] MODE_ACTIVE_LOW  = 2'd2;
  localparam logic [1:0] MODE_NONE        = 2'd3;

  localparam logic [1:0] REG_OUTPUT_MODE   = 2'd0;
  localparam logic [1:0] REG_COUNT_BEEP    = 2'd1;
  localparam logic [1:0] REG_FINAL_WINDOW  = 2'd2;

  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0]  RESET_OUTPUT_MODE  = MODE_ACTIVE_HIGH;
  localparam logic [9:0]  RESET_COUNT_BEEP   = 10'd120;
  localparam logic [15:0] RESET_FINAL_WINDOW = 16'd3000;

  localparam logic [31:0] READY_ON_MS    = 32'd150;
  localparam logic [31:0] READY_OFF_MS   = 32'd150;
  localparam logic [31:0] READY_TOTAL_MS = 2 * READY_ON_MS + READY_OFF_MS;
  localparam logic [11:0] WAIT_ON_MS     = 12'd500;

  localparam logic [10:0] INTERVAL_MIN_MS = 11'd200;
  localparam logic [10:0] INTERVAL_MAX_MS = 11'd1200;
  // Smallest remaining time whose scaled interval exceeds the maximum.
  localparam logic [23:0] INTERVAL_SAT_REMAIN = 24'd20017;

  localparam logic [7:0] DUTY_PASSIVE_ON = 8'd128;
  localparam logic [7:0] DUTY_FULL       = 8'd255;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [1:0]  flight_phase;
    logic        arm_wait;
    logic [23:0] remain_ms;
  } upd_t;

  typedef struct packed {
    logic       buzzer_on;
    logic [7:0] pwm_duty;
    logic       pin_level;
    logic       changed;
  } res_t;

  typedef struct packed {
    logic [1:0]  output_mode;
    logic [9:0]  beep_len_ms;
    logic [15:0] final_window_ms;
  } cfg_t;

endpackage

// ----- hw/rtl/buzzer_alert_pattern_sequencer_core.sv -----
// Buzzer alert pattern sequencer: top level with request and result registers.
//
// Each request on the upd channel carries the time in ms, the flight phase, the
// arm-wait flag and the remaining countdown. Every request yields exactly one result
// on the res channel: buzzer on/off, PWM duty, plain pin level and a changed flag.
// A request is taken when upd_valid is high and upd_stall is low; a result is taken
// when res_valid is high and res_stall is low.
// From request to result, a request passes the request register, then the result
// register that the pattern logic writes. Throughput is one request per cycle while
// the receiver does not stall, set by the single pass through the pattern logic and
// the 2500 ms period remainder unit between the two registers.
// When the receiver stalls, the result is held and one more request waits in the
// request register; only then is upd_stall raised. Reset empties both registers,
// clears the pattern state and loads the register defaults; the user must write the
// configuration port (APB) only while the block is idle, which it does not enforce.
`include "buzzer_alert_pattern_sequencer_core_macros.svh"

module buzzer_alert_pattern_sequencer_core
  import bapsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              upd_valid,
  output logic              upd_stall,
  input  upd_t              upd,
  output logic              res_valid,
  input  logic              res_stall,
  output res_t              res
);

  cfg_t cfg;
  logic a_valid;
  upd_t a_data;
  logic advance;
  res_t result;

  bapsc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bapsc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (a_data),
    .commit (advance),
    .result (result)
  );

  assign advance   = a_valid && (!res_valid || !res_stall);
  assign upd_stall = a_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!upd_stall) begin
      a_valid <= upd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_valid && !upd_stall) begin
      a_data <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= result;
    end
  end

  `BAPSC_ASSERT_NOW(a_stall_needs_full_out, upd_stall, res_valid && res_stall, "stall without a held result")
  `BAPSC_ASSERT_NEXT(a_advance_gives_result, advance, res_valid, "advanced request gave no result")
  `BAPSC_ASSERT_NEXT(a_stalled_request_kept, upd_stall, a_valid, "stalled request was dropped")
  `BAPSC_ASSERT_NOW(a_pin_matches_duty, res_valid && res.pin_level, res.pwm_duty == DUTY_FULL, "pin high without full duty")

endmodule

// ----- hw/rtl/bapsc_cfg.sv -----
// APB register file holding the buzzer drive mode and beep timing settings.
module bapsc_cfg
  import bapsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_mode     <= RESET_OUTPUT_MODE;
      cfg.beep_len_ms     <= RESET_COUNT_BEEP;
      cfg.final_window_ms <= RESET_FINAL_WINDOW;
    end else if (wr) begin
      unique case (paddr[ADDR_W-1:2])
        REG_OUTPUT_MODE:  cfg.output_mode     <= pwdata[1:0];
        REG_COUNT_BEEP:   cfg.beep_len_ms     <= pwdata[9:0];
        REG_FINAL_WINDOW: cfg.final_window_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_OUTPUT_MODE:  prdata = {30'd0, cfg.output_mode};
      REG_COUNT_BEEP:   prdata = {22'd0, cfg.beep_len_ms};
      REG_FINAL_WINDOW: prdata = {16'd0, cfg.final_window_ms};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ----- hw/rtl/bapsc_wait_mod.sv -----
// Remainder of a 32-bit millisecond span by the 2500 ms arm-wait period.
module bapsc_wait_mod
  import bapsc_pkg::*;
(
  input  logic [31:0] span,
  output logic [11:0] rem
);

  // The period is 4 * 625: the two low bits pass through, the rest is reduced by 625
  // with an exact reciprocal multiply for all 30-bit dividends.
  localparam logic [29:0] RECIP     = 30'd879609303;
  localparam int unsigned RECIP_SH  = 39;
  localparam logic [9:0]  DIV_ODD   = 10'd625;

  logic [29:0] high;
  logic [59:0] prod;
  logic [20:0] quot;
  logic [30:0] back;
  logic [29:0] diff;

  assign high = span[31:2];
  assign prod = 60'(high) * 60'(RECIP);
  assign quot = prod[RECIP_SH+20:RECIP_SH];
  assign back = 31'(quot) * 31'(DIV_ODD);
  assign diff = high - back[29:0];
  assign rem  = {diff[9:0], span[1:0]};

endmodule

// ----- hw/rtl/bapsc_seq.sv -----
// Pattern state and combinational result logic for the buzzer alert sequencer.
module bapsc_seq
  import bapsc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  upd_t item,
  input  logic commit,
  output res_t result
);

  localparam logic [17:0] RECIP_100 = 18'd167773;
  localparam int unsigned RECIP_SH  = 24;

  logic [1:0]  prev_phase;
  logic        prev_arm_wait;
  logic [31:0] arm_wait_start;
  logic [31:0] next_beep_time;
  logic [31:0] beep_end_time;
  logic        beep_pending;
  logic        ready_done;
  logic [31:0] ready_start;
  logic        ready_active;
  logic        last_on;
  logic [1:0]  last_mode;

  logic [31:0] arm_wait_start_next;
  logic [31:0] next_beep_time_next;
  logic [31:0] beep_end_time_next;
  logic        beep_pending_next;
  logic        ready_done_next;
  logic [31:0] ready_start_next;
  logic        ready_active_next;

  logic [1:0]  phase;
  logic [31:0] now;
  logic [31:0] wait_start;
  logic [11:0] wait_rem;
  logic [16:0] scaled;
  logic [34:0] scaled_prod;
  logic [10:0] quot;
  logic [10:0] interval;
  logic        on;

  logic [31:0] nbt_base;
  logic        pend_base;
  logic [31:0] due_diff;
  logic [31:0] end_diff;
  logic        ready_start_now;
  logic        ready_base;
  logic [31:0] ready_t;
  logic [7:0]  duty;

  assign now   = item.now_ms;
  assign phase = (item.flight_phase == PH_RESERVED) ? PH_OTHER : item.flight_phase;

  assign wait_start = (item.arm_wait && !prev_arm_wait) ? now : arm_wait_start;

  bapsc_wait_mod u_wait_mod (
    .span (now - wait_start),
    .rem  (wait_rem)
  );

  // Countdown interval: remain * 6 / 100, clamped. Large remains saturate directly.
  assign scaled      = 17'(item.remain_ms[14:0]) * 17'd6;
  assign scaled_prod = 35'(scaled) * 35'(RECIP_100);
  assign quot        = scaled_prod[RECIP_SH+10:RECIP_SH];

  always_comb begin
    if (item.remain_ms >= INTERVAL_SAT_REMAIN) begin
      interval = INTERVAL_MAX_MS;
    end else if (quot < INTERVAL_MIN_MS) begin
      interval = INTERVAL_MIN_MS;
    end else begin
      interval = quot;
    end
  end

  always_comb begin
    on                  = 1'b0;
    nbt_base            = next_beep_time;
    pend_base           = beep_pending;
    next_beep_time_next = next_beep_time;
    beep_end_time_next  = beep_end_time;
    beep_pending_next   = beep_pending;
    due_diff            = '0;
    end_diff            = '0;

    if (phase == PH_COUNTDOWN) begin
      if (prev_phase != PH_COUNTDOWN) begin
        nbt_base  = now;
        pend_base = 1'b0;
      end
      next_beep_time_next = nbt_base;
      beep_pending_next   = pend_base;
      if (item.remain_ms <= {8'd0, cfg.final_window_ms}) begin
        on = 1'b1;
      end else begin
        due_diff = now - nbt_base;
        if (!due_diff[31]) begin
          beep_end_time_next  = now + 32'(cfg.beep_len_ms);
          beep_pending_next   = 1'b1;
          next_beep_time_next = now + 32'(interval);
        end
        end_diff = now - beep_end_time_next;
        on       = beep_pending_next && end_diff[31];
      end
    end else if (item.arm_wait) begin
      on = (wait_rem < WAIT_ON_MS);
    end

    ready_start_now     = !ready_done && (prev_phase == PH_ARMING) && (phase != PH_ARMING);
    ready_done_next     = ready_done || ready_start_now;
    ready_base          = ready_active || ready_start_now;
    ready_start_next    = ready_start_now ? now : ready_start;
    ready_active_next   = ready_base;
    arm_wait_start_next = wait_start;
    ready_t             = now - ready_start_next;

    if (ready_base) begin
      if (ready_t < READY_TOTAL_MS) begin
        on = (ready_t < READY_ON_MS) || (ready_t >= READY_ON_MS + READY_OFF_MS);
      end else begin
        ready_active_next = 1'b0;
        if (item.arm_wait) begin
          arm_wait_start_next = now;
        end
      end
    end

    if (cfg.output_mode == MODE_PASSIVE) begin
      duty = on ? DUTY_PASSIVE_ON : 8'd0;
    end else begin
      duty = (on != (cfg.output_mode == MODE_ACTIVE_LOW)) ? DUTY_FULL : 8'd0;
    end

    result.buzzer_on = on;
    result.pwm_duty  = duty;
    result.pin_level = (cfg.output_mode != MODE_PASSIVE) && (duty != 8'd0);
    result.changed   = (on != last_on) || (cfg.output_mode != last_mode);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phase     <= PH_ARMING;
      prev_arm_wait  <= 1'b0;
      arm_wait_start <= '0;
      next_beep_time <= '0;
      beep_end_time  <= '0;
      beep_pending   <= 1'b0;
      ready_done     <= 1'b0;
      ready_start    <= '0;
      ready_active   <= 1'b0;
      last_on        <= 1'b0;
      last_mode      <= MODE_NONE;
    end else if (commit) begin
      prev_phase     <= phase;
      prev_arm_wait  <= item.arm_wait;
      arm_wait_start <= arm_wait_start_next;
      next_beep_time <= next_beep_time_next;
      beep_end_time  <= beep_end_time_next;
      beep_pending   <= beep_pending_next;
      ready_done     <= ready_done_next;
      ready_start    <= ready_start_next;
      ready_active   <= ready_active_next;
      last_on        <= on;
      last_mode      <= cfg.output_mode;
    end
  end

endmodule
